@@ rtl/gsfb_pkg.sv @@
// Shared types and constants for the graphic LCD shadow frame buffer.
package gsfb_pkg;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [7:0] ADDR_CMD   = 8'h80;
    localparam int         HALF_ROWS  = 32;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] x_pos;
        logic [5:0] y_pos;
        logic       pixel_color;
        logic [4:0] row_index;
    } in_item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        OUT_VCMD,
        OUT_HCMD,
        OUT_HI,
        OUT_LO
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_WR,
        ST_FILL,
        ST_FL_VCMD,
        ST_FL_HCMD,
        ST_FL_HI,
        ST_FL_LO
    } state_t;

    typedef struct packed {
        logic     load_item;
        logic     dirty_set;
        logic     mem_rd;
        logic     rd_pix;
        logic     mem_wr;
        logic     wr_sweep;
        logic     sweep_inc;
        logic     word_inc;
        logic     out_load;
        out_sel_t out_sel;
        logic     flush_done;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic pix_ok;
        logic flush_ok;
        logic sweep_last;
        logic word_last;
    } dp_status_t;

endpackage

@@ rtl/gsfb_datapath.sv @@
// Frame store, address generation, dirty flag and output register.
module gsfb_datapath #(
    parameter int RAM_ROWS      = 32,
    parameter int WORDS_PER_ROW = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gsfb_pkg::in_item_t    s_data,
    input  gsfb_pkg::dp_cmd_t     cmd,
    output gsfb_pkg::dp_status_t  status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gsfb_pkg::out_item_t   m_data
);
    import gsfb_pkg::*;

    localparam int NUM_WORDS = RAM_ROWS * WORDS_PER_ROW;
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int WORD_W    = $clog2(WORDS_PER_ROW);

    logic [15:0] mem [NUM_WORDS];

    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] pix_addr_reg;
    logic [3:0]        bit_reg;
    logic              color_reg;
    logic              fill_val_reg;
    logic [4:0]        row_reg;
    logic              row_last_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [WORD_W-1:0] word_cnt_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic              dirty_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    // pixel address mapping: lower half of the panel sits at x + 128
    logic [7:0]        x_map;
    logic [4:0]        y_map;
    logic [3:0]        col;
    logic [ADDR_W-1:0] pix_addr;
    logic [WORD_W-1:0] rd_word;
    logic [ADDR_W-1:0] flush_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       mask;
    logic [15:0]       pix_word;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    out_item_t         out_next;

    assign x_map    = {s_data.y_pos[5], s_data.x_pos};
    assign y_map    = s_data.y_pos[4:0];
    assign col      = x_map[7:4];
    assign pix_addr = ADDR_W'(32'(y_map) * WORDS_PER_ROW + 32'(col));

    assign rd_word    = cmd.word_inc ? word_cnt_reg + WORD_W'(1) : word_cnt_reg;
    assign flush_addr = row_base_reg + ADDR_W'(rd_word);
    assign rd_addr    = cmd.rd_pix ? pix_addr : flush_addr;

    assign mask     = 16'h0001 << bit_reg;
    assign pix_word = color_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
    assign wr_addr  = cmd.wr_sweep ? sweep_cnt_reg : pix_addr_reg;
    assign wr_data  = cmd.wr_sweep ? {16{fill_val_reg}} : pix_word;

    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.pix_ok     = (32'(y_map) < RAM_ROWS) && (32'(col) < WORDS_PER_ROW);
    assign status.flush_ok   = dirty_reg && (32'(s_data.row_index) < RAM_ROWS);
    assign status.sweep_last = (sweep_cnt_reg == ADDR_W'(NUM_WORDS - 1));
    assign status.word_last  = (word_cnt_reg == WORD_W'(WORDS_PER_ROW - 1));

    always_comb begin
        out_next.is_data  = 1'b1;
        out_next.bus_byte = rd_data_reg[15:8];
        out_next.last     = 1'b0;
        case (cmd.out_sel)
            OUT_VCMD: begin
                out_next.is_data  = 1'b0;
                out_next.bus_byte = ADDR_CMD + {3'b000, row_reg};
            end
            OUT_HCMD: begin
                out_next.is_data  = 1'b0;
                out_next.bus_byte = ADDR_CMD;
            end
            OUT_HI: begin
                out_next.bus_byte = rd_data_reg[15:8];
            end
            OUT_LO: begin
                out_next.bus_byte = rd_data_reg[7:0];
                out_next.last     = status.word_last;
            end
            default: begin
                out_next.bus_byte = rd_data_reg[15:8];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            pix_addr_reg <= pix_addr;
            bit_reg      <= ~x_map[3:0];
            color_reg    <= s_data.pixel_color;
            row_reg      <= s_data.row_index;
            row_last_reg <= (32'(s_data.row_index) == RAM_ROWS - 1);
            row_base_reg <= ADDR_W'(32'(s_data.row_index) * WORDS_PER_ROW);
        end
        if (cmd.out_load) begin
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_val_reg  <= 1'b0;
            sweep_cnt_reg <= '0;
            word_cnt_reg  <= '0;
            dirty_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                fill_val_reg  <= s_data.pixel_color;
                sweep_cnt_reg <= '0;
                word_cnt_reg  <= '0;
            end else begin
                if (cmd.sweep_inc) begin
                    sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
                end
                if (cmd.word_inc) begin
                    word_cnt_reg <= word_cnt_reg + WORD_W'(1);
                end
            end
            if (cmd.dirty_set) begin
                dirty_reg <= 1'b1;
            end else if (cmd.flush_done && row_last_reg) begin
                dirty_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/gsfb_ctrl.sv @@
// Sequencer for clear pass, pixel read-modify-write, fill and row flush.
module gsfb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            operation,
    input  gsfb_pkg::dp_status_t  status,
    output gsfb_pkg::dp_cmd_t     cmd
);
    import gsfb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR, ST_FILL: begin
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (operation)
                        OP_PIXEL: if (status.pix_ok) state_next = ST_PIX_WR;
                        OP_FILL:  state_next = ST_FILL;
                        OP_FLUSH: if (status.flush_ok) state_next = ST_FL_VCMD;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_WR: state_next = ST_IDLE;
            ST_FL_VCMD: begin
                if (status.out_free) state_next = ST_FL_HCMD;
            end
            ST_FL_HCMD: begin
                if (status.out_free) state_next = ST_FL_HI;
            end
            ST_FL_HI: begin
                if (status.out_free) state_next = ST_FL_LO;
            end
            ST_FL_LO: begin
                if (status.out_free) begin
                    state_next = status.word_last ? ST_IDLE : ST_FL_HI;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        cmd.out_sel = OUT_VCMD;
        case (state_reg)
            ST_CLEAR, ST_FILL: begin
                cmd.mem_wr    = 1'b1;
                cmd.wr_sweep  = 1'b1;
                cmd.sweep_inc = 1'b1;
            end
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
                if (s_valid) begin
                    case (operation)
                        OP_PIXEL: begin
                            // read the target word now, write it back next cycle
                            cmd.mem_rd    = status.pix_ok;
                            cmd.rd_pix    = 1'b1;
                            cmd.dirty_set = status.pix_ok;
                        end
                        OP_FILL:  cmd.dirty_set = 1'b1;
                        default:  cmd.dirty_set = 1'b0;
                    endcase
                end
            end
            ST_PIX_WR: cmd.mem_wr = 1'b1;
            ST_FL_VCMD: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = OUT_VCMD;
            end
            ST_FL_HCMD: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = OUT_HCMD;
                cmd.mem_rd   = status.out_free;
            end
            ST_FL_HI: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = OUT_HI;
            end
            ST_FL_LO: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = OUT_LO;
                if (status.out_free) begin
                    // prefetch the next word as the low byte leaves
                    cmd.flush_done = status.word_last;
                    cmd.word_inc   = !status.word_last;
                    cmd.mem_rd     = !status.word_last;
                end
            end
            default: s_ready = 1'b0;
        endcase
    end

endmodule

@@ rtl/glcd_shadow_framebuffer.sv @@
// Top level of the graphic LCD shadow frame buffer.
//
//  channel | dir | ports                      | payload
//  --------+-----+----------------------------+-----------------------------
//  input   | in  | s_valid, s_ready, s_data   | operation, x/y, color, row
//  result  | out | m_valid, m_ready, m_data   | is_data, bus_byte, last
//
// Pixel write: the word is read, then written back. Fill: the accept cycle, then one
// word per cycle through the single write port. Row flush: the accept cycle, 2 command
// bytes, then 2 bytes per word at one byte per cycle when the result side keeps up,
// each word read overlapping the byte ahead of it; the output register stalls the
// sequencer. A clean flush or an unused operation is accepted and does nothing else.
// After reset a clearing pass writes zeros to all RAM_ROWS*WORDS_PER_ROW words,
// one per cycle, before the first input transfer is taken.
module glcd_shadow_framebuffer #(
    parameter int RAM_ROWS      = 32,
    parameter int WORDS_PER_ROW = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gsfb_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gsfb_pkg::out_item_t  m_data
);
    import gsfb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    gsfb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .operation (s_data.operation),
        .status    (status),
        .cmd       (cmd)
    );

    gsfb_datapath #(
        .RAM_ROWS      (RAM_ROWS),
        .WORDS_PER_ROW (WORDS_PER_ROW)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the graphic LCD shadow frame buffer.
`timescale 1ns / 100ps

module tb;
    import gsfb_pkg::*;

    localparam int RAM_ROWS      = 32;
    localparam int WORDS_PER_ROW = 16;
    localparam int NUM_WORDS     = RAM_ROWS * WORDS_PER_ROW;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int MAX_GAP      = 12;
    localparam int ITEM_TARGET  = 110;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * NUM_WORDS;
    localparam int IDLE_LIMIT   = 8000;

    typedef struct {
        in_item_t   item;
        bit         typed;
        bit         emits;
        logic [7:0] fill_byte;
    } stim_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic [15:0] shadow_ram [NUM_WORDS];
    logic        shadow_dirty;
    out_item_t   lcd_bytes_due [$];
    stim_row_t   directed_rows [$];

    int  err_count    = 0;
    int  sent_items   = 0;
    int  idle_cycles  = 0;
    bit  tx_burst     = 1'b0;
    bit  rx_burst     = 1'b0;
    bit  hold_armed   = 1'b0;

    always #1 aclk = ~aclk;

    glcd_shadow_framebuffer #(
        .RAM_ROWS      (RAM_ROWS),
        .WORDS_PER_ROW (WORDS_PER_ROW)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ---------------------------------------------------------------- items
    function automatic in_item_t noise_item(logic [1:0] op);
        in_item_t it;
        it.operation   = op;
        it.x_pos       = 7'($urandom);
        it.y_pos       = 6'($urandom);
        it.pixel_color = 1'($urandom);
        it.row_index   = 5'($urandom);
        return it;
    endfunction

    function automatic in_item_t pixel_item(int x, int y, bit color);
        in_item_t it;
        it             = noise_item(OP_PIXEL);
        it.x_pos       = 7'(x);
        it.y_pos       = 6'(y);
        it.pixel_color = color;
        return it;
    endfunction

    function automatic in_item_t fill_item(bit color);
        in_item_t it;
        it             = noise_item(OP_FILL);
        it.pixel_color = color;
        return it;
    endfunction

    function automatic in_item_t flush_item(int row);
        in_item_t it;
        it           = noise_item(OP_FLUSH);
        it.row_index = 5'(row);
        return it;
    endfunction

    function automatic stim_row_t row_of(in_item_t it, bit typed = 1'b0, bit emits = 1'b0,
                                         logic [7:0] fill_byte = 8'h00);
        stim_row_t r;
        r.item      = it;
        r.typed     = typed;
        r.emits     = emits;
        r.fill_byte = fill_byte;
        return r;
    endfunction

    // ------------------------------------------------------------ predictor
    task automatic due(logic is_data, logic [7:0] bus_byte, logic last);
        out_item_t o;
        o.is_data  = is_data;
        o.bus_byte = bus_byte;
        o.last     = last;
        lcd_bytes_due.push_back(o);
    endtask

    // Row flush whose data bytes are all the same fill value.
    task automatic due_uniform_row(int row, logic [7:0] fill_byte);
        due(1'b0, ADDR_CMD + 8'(row), 1'b0);
        due(1'b0, ADDR_CMD, 1'b0);
        for (int w = 0; w < WORDS_PER_ROW; w++) begin
            due(1'b1, fill_byte, 1'b0);
            due(1'b1, fill_byte, w == WORDS_PER_ROW - 1);
        end
    endtask

    task automatic shadow_apply(in_item_t it, bit record);
        int xx;
        int yy;
        int col;
        int bitpos;
        logic [15:0] word;
        case (it.operation)
            OP_PIXEL: begin
                xx = it.x_pos;
                yy = it.y_pos;
                // lower half of the panel sits in the right half of GDRAM
                if (yy >= HALF_ROWS) begin
                    xx += 128;
                    yy -= HALF_ROWS;
                end
                col    = xx / 16;
                bitpos = 15 - (xx % 16);
                if (yy < RAM_ROWS && col < WORDS_PER_ROW) begin
                    shadow_ram[yy * WORDS_PER_ROW + col][bitpos] = it.pixel_color;
                    shadow_dirty = 1'b1;
                end
            end
            OP_FILL: begin
                foreach (shadow_ram[i]) shadow_ram[i] = {16{it.pixel_color}};
                shadow_dirty = 1'b1;
            end
            OP_FLUSH: begin
                if (shadow_dirty && it.row_index < RAM_ROWS) begin
                    if (record) begin
                        due(1'b0, ADDR_CMD + 8'(it.row_index), 1'b0);
                        due(1'b0, ADDR_CMD, 1'b0);
                        for (int w = 0; w < WORDS_PER_ROW; w++) begin
                            word = shadow_ram[it.row_index * WORDS_PER_ROW + w];
                            due(1'b1, word[15:8], 1'b0);
                            due(1'b1, word[7:0], w == WORDS_PER_ROW - 1);
                        end
                    end
                    if (it.row_index == RAM_ROWS - 1) shadow_dirty = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // --------------------------------------------------------------- sender
    task automatic send_item(in_item_t it, bit typed = 1'b0, bit emits = 1'b0,
                             logic [7:0] fill_byte = 8'h00);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // transfer taken at this edge
        sent_items++;
        if (typed && emits) due_uniform_row(it.row_index, fill_byte);
        shadow_apply(it, !typed);
    endtask

    // ------------------------------------------------------------- receiver
    task automatic flag_field(string name, int expv, int act);
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, act);
        err_count++;
    endtask

    task automatic check_byte(out_item_t got);
        out_item_t want;
        if (lcd_bytes_due.size() == 0) begin
            $error("unexpected result transfer: is_data=%0b bus_byte=0x%0h last=%0b",
                   got.is_data, got.bus_byte, got.last);
            err_count++;
            return;
        end
        want = lcd_bytes_due.pop_front();
        if (got.is_data !== want.is_data)   flag_field("is_data", want.is_data, got.is_data);
        if (got.bus_byte !== want.bus_byte) flag_field("bus_byte", want.bus_byte, got.bus_byte);
        if (got.last !== want.last)         flag_field("last", want.last, got.last);
    endtask

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_armed) begin
                // long back-pressure so the block fills and stalls its input
                hold_armed = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_byte(m_data);
        end
    end

    // ------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("glcd_shadow_framebuffer verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------- stimulus
    initial begin
        int n;
        foreach (shadow_ram[i]) shadow_ram[i] = 16'h0000;
        shadow_dirty = 1'b0;

        // clean flushes, an unused operation, corners of both panel halves, fills, redundant writes
        directed_rows.push_back(row_of(flush_item(0), 1'b1, 1'b0));
        directed_rows.push_back(row_of(noise_item(OP_UNUSED), 1'b1, 1'b0));
        directed_rows.push_back(row_of(pixel_item(0, 0, 1'b1)));
        directed_rows.push_back(row_of(pixel_item(127, 0, 1'b1)));
        directed_rows.push_back(row_of(pixel_item(0, 63, 1'b1)));
        directed_rows.push_back(row_of(pixel_item(127, 63, 1'b1)));
        directed_rows.push_back(row_of(pixel_item(64, 31, 1'b1)));
        directed_rows.push_back(row_of(pixel_item(15, 32, 1'b1)));
        directed_rows.push_back(row_of(flush_item(0)));
        directed_rows.push_back(row_of(flush_item(31)));
        directed_rows.push_back(row_of(flush_item(31), 1'b1, 1'b0));
        directed_rows.push_back(row_of(fill_item(1'b1)));
        directed_rows.push_back(row_of(flush_item(0), 1'b1, 1'b1, 8'hff));
        directed_rows.push_back(row_of(pixel_item(0, 0, 1'b0)));
        directed_rows.push_back(row_of(pixel_item(127, 63, 1'b0)));
        directed_rows.push_back(row_of(flush_item(0)));
        directed_rows.push_back(row_of(flush_item(16), 1'b1, 1'b1, 8'hff));
        directed_rows.push_back(row_of(flush_item(31)));
        directed_rows.push_back(row_of(fill_item(1'b0)));
        directed_rows.push_back(row_of(flush_item(31), 1'b1, 1'b1, 8'h00));
        directed_rows.push_back(row_of(pixel_item(33, 5, 1'b1)));
        directed_rows.push_back(row_of(pixel_item(33, 5, 1'b0)));
        directed_rows.push_back(row_of(flush_item(5), 1'b1, 1'b1, 8'h00));
        directed_rows.push_back(row_of(flush_item(31), 1'b1, 1'b1, 8'h00));
        directed_rows.push_back(row_of(flush_item(7), 1'b1, 1'b0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].emits, directed_rows[i].fill_byte);

        // random frames: maybe a fill, draw a few pixels, then flush some rows or the whole panel, maybe an unused item
        hold_armed = 1'b1;
        while (sent_items < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 5) send_item(fill_item(1'($urandom)));
            n = $urandom_range(0, 6);
            repeat (n)
                send_item(pixel_item($urandom_range(0, 127), $urandom_range(0, 63),
                                     1'($urandom)));
            if ($urandom_range(0, 9) == 0) begin
                for (int r = 0; r < RAM_ROWS; r++) send_item(flush_item(r));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(flush_item($urandom_range(0, RAM_ROWS - 1)));
                if ($urandom_range(0, 1) == 1) send_item(flush_item(RAM_ROWS - 1));
            end
            if ($urandom_range(0, 4) == 0) send_item(noise_item(OP_UNUSED));
        end
        s_valid <= 1'b0;

        while (lcd_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0)
            $display("glcd_shadow_framebuffer verification clean");
        else
            $display("glcd_shadow_framebuffer verification failed");
        $finish;
    end

endmodule
